### hw/rtl/tel_pkg.sv
// shared types and codes for the triangle edge list builder
`timescale 1ns / 1ps

package tel_pkg;

   localparam logic ACTION_LOAD = 1'b0;
   localparam logic ACTION_READ = 1'b1;

   localparam logic KIND_SUMMARY = 1'b0;
   localparam logic KIND_EDGE    = 1'b1;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_RANGE    = 2'd1;
   localparam logic [1:0] STATUS_FULL     = 2'd2;
   localparam logic [1:0] STATUS_BAD_READ = 2'd3;

   localparam int VERTEX_WIDTH = 12;
   localparam int FACE_WIDTH   = 10;
   localparam int TOTAL_WIDTH  = 12;
   localparam int CSR_WIDTH    = 13;
   localparam logic [CSR_WIDTH-1:0] VERTEX_COUNT_RESET = 13'd4096;

   typedef struct packed {
      logic                    action;
      logic [VERTEX_WIDTH-1:0] vertex_a;
      logic [VERTEX_WIDTH-1:0] vertex_b;
      logic [VERTEX_WIDTH-1:0] vertex_c;
      logic                    last_triangle;
      logic [11:0]             edge_number;
   } req_type;

   typedef struct packed {
      logic                    kind;
      logic [1:0]              status;
      logic [TOTAL_WIDTH-1:0]  edge_total;
      logic [VERTEX_WIDTH-1:0] vertex_low;
      logic [VERTEX_WIDTH-1:0] vertex_high;
      logic [FACE_WIDTH-1:0]   face_first;
      logic [FACE_WIDTH-1:0]   face_second;
      logic                    boundary;
   } rsp_type;

   typedef struct packed {
      req_type req;
      logic    in_range;
   } item_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOAD,
      ST_EDGE_SEL,
      ST_EDGE_WR,
      ST_MATCH_TRI,
      ST_MATCH_SEL,
      ST_MATCH_HEAD,
      ST_MATCH_EDGE,
      ST_MATCH_CHK,
      ST_SWEEP_RD,
      ST_SWEEP_WR,
      ST_SUMMARY,
      ST_READ,
      ST_READ_WAIT,
      ST_RESULT
   } back_state_type;

endpackage

### hw/rtl/triangle_edge_list_builder.sv
// top level of the triangle edge list builder
`timescale 1ns / 1ps

//  channel | direction | handshake           | payload
//  req     | in        | req_valid/req_stall | tel_pkg::req_type
//  rsp     | out       | rsp_valid/rsp_stall | tel_pkg::rsp_type
//  csr     | in        | csr_write_enable    | vertex_count, 13 bits
//
//  a stored triangle takes the load state, an edge select per edge and an
//  edge write per ascending one, a dropped one the load state only; each
//  edge step reads the head table before the chain append; the last
//  triangle adds the match walk over each stored triangle, its descending
//  edges and the chain entries visited, then a sweep over the edges to empty
//  the chain heads, then the summary. Requests queue up to two deep while the
//  head table clears after reset; rsp_stall holds the output and result states

module triangle_edge_list_builder #(
   parameter int MAX_VERTICES  = 4096,
   parameter int MAX_TRIANGLES = 1024,
   parameter int MAX_EDGES     = 3072
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  tel_pkg::req_type              req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output tel_pkg::rsp_type              rsp_payload,
   input  logic                          csr_write_enable,
   input  logic [tel_pkg::CSR_WIDTH-1:0] csr_write_data
);

   // queue between intake and the sequencer
   logic              item_valid;
   logic              item_pop;
   tel_pkg::item_type item_data;

   // intake: range check and a two entry queue
   tel_front #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .item_valid       (item_valid),
      .item_pop         (item_pop),
      .item_data        (item_data)
   );

   // sequencer: triangle and edge stores, vertex chains, match pass
   tel_back #(
      .MAX_VERTICES  (MAX_VERTICES),
      .MAX_TRIANGLES (MAX_TRIANGLES),
      .MAX_EDGES     (MAX_EDGES)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (item_valid),
      .item_pop    (item_pop),
      .item_data   (item_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // the sequencer never takes from an empty queue
   a_pop_needs_item: assert property (@(posedge clock) disable iff (reset)
      item_pop |-> item_valid)
      else $error("pop from empty request queue");

   // a summary never carries the bad read code
   a_summary_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.kind == tel_pkg::KIND_SUMMARY) |->
      (rsp_payload.status != tel_pkg::STATUS_BAD_READ))
      else $error("summary with bad read status");

   // a summary has no edge fields
   a_summary_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.kind == tel_pkg::KIND_SUMMARY) |->
      (rsp_payload.vertex_low == '0) && (rsp_payload.boundary == 1'b0))
      else $error("summary carries edge data");

   // boundary edges report the same face twice
   a_boundary_faces: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.boundary |->
      (rsp_payload.face_first == rsp_payload.face_second))
      else $error("boundary edge with two faces");

endmodule

### hw/rtl/tel_front.sv
// front end: request intake, vertex range check and two entry queue
`timescale 1ns / 1ps

module tel_front #(
   parameter int MAX_VERTICES = 4096
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  tel_pkg::req_type                req_payload,
   input  logic                            csr_write_enable,
   input  logic [tel_pkg::CSR_WIDTH-1:0]   csr_write_data,
   output logic                            item_valid,
   input  logic                            item_pop,
   output tel_pkg::item_type               item_data
);

   logic [tel_pkg::CSR_WIDTH-1:0] vertex_count_ff, vertex_count_in;
   tel_pkg::item_type             slot_ff [2];
   logic                          wr_ptr_ff, wr_ptr_in;
   logic                          rd_ptr_ff, rd_ptr_in;
   logic [1:0]                    count_ff, count_in;
   logic                          push;
   logic                          in_range;
   tel_pkg::item_type             new_item;

   assign req_stall  = (count_ff == 2'd2);
   assign push       = req_valid && !req_stall;
   assign item_valid = (count_ff != 2'd0);
   assign item_data  = slot_ff[rd_ptr_ff];

   // index must be below both the register and the table size
   always_comb begin
      in_range =
         (32'(req_payload.vertex_a) < 32'(vertex_count_ff)) &&
         (32'(req_payload.vertex_b) < 32'(vertex_count_ff)) &&
         (32'(req_payload.vertex_c) < 32'(vertex_count_ff)) &&
         (32'(req_payload.vertex_a) < MAX_VERTICES) &&
         (32'(req_payload.vertex_b) < MAX_VERTICES) &&
         (32'(req_payload.vertex_c) < MAX_VERTICES);
      new_item.req      = req_payload;
      new_item.in_range = in_range;
   end

   always_comb begin
      vertex_count_in = csr_write_enable ? csr_write_data : vertex_count_ff;
      wr_ptr_in       = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in       = item_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in        = count_ff + 2'(push) - 2'(item_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= tel_pkg::VERTEX_COUNT_RESET;
         wr_ptr_ff       <= 1'b0;
         rd_ptr_ff       <= 1'b0;
         count_ff        <= 2'd0;
      end else begin
         vertex_count_ff <= vertex_count_in;
         wr_ptr_ff       <= wr_ptr_in;
         rd_ptr_ff       <= rd_ptr_in;
         count_ff        <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

### hw/rtl/tel_back.sv
// back end: mesh stores, chain building, match pass and results
`timescale 1ns / 1ps

module tel_back #(
   parameter int MAX_VERTICES  = 4096,
   parameter int MAX_TRIANGLES = 1024,
   parameter int MAX_EDGES     = 3072
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              item_valid,
   output logic              item_pop,
   input  tel_pkg::item_type item_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tel_pkg::rsp_type  rsp_payload
);

   localparam int VW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int TW  = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
   localparam int EW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int CW  = $clog2(MAX_EDGES + 1);
   localparam int TCW = $clog2(MAX_TRIANGLES + 1);
   localparam int XW  = tel_pkg::VERTEX_WIDTH;

   typedef struct packed {
      logic          valid;
      logic [EW-1:0] first;
      logic [EW-1:0] tail;
   } head_type;

   typedef struct packed {
      logic [XW-1:0] lo;
      logic [XW-1:0] hi;
      logic [TW-1:0] f0;
      logic [TW-1:0] f1;
   } edge_type;

   // memories
   logic [3*XW-1:0] tri_mem  [MAX_TRIANGLES];
   edge_type        edge_mem [MAX_EDGES];
   logic [EW-1:0]   next_mem [MAX_EDGES];
   head_type        head_mem [MAX_VERTICES];

   logic [3*XW-1:0] tri_q;
   edge_type        edge_q;
   logic [EW-1:0]   next_q;
   head_type        head_q;

   logic            tri_we;
   logic [TW-1:0]   tri_waddr, tri_raddr;
   logic [3*XW-1:0] tri_wdata;
   logic            edge_we;
   logic [EW-1:0]   edge_waddr, edge_raddr;
   edge_type        edge_wdata;
   logic            next_we;
   logic [EW-1:0]   next_waddr;
   logic [EW-1:0]   next_wdata;
   logic            head_we;
   logic [VW-1:0]   head_waddr, head_raddr;
   head_type        head_wdata;

   tel_pkg::back_state_type state_ff, state_in;
   tel_pkg::item_type       item_ff, item_in;
   logic                    mf_ff, mf_in;
   logic [1:0]              err_ff, err_in;
   logic [TCW-1:0]          tri_total_ff, tri_total_in;
   logic [CW-1:0]           ecount_ff, ecount_in;
   logic [TW-1:0]           cur_tri_ff, cur_tri_in;
   logic [1:0]              b_ff, b_in;
   logic [TCW-1:0]          mt_ff, mt_in;
   logic [EW-1:0]           cur_ff, cur_in;
   logic [EW-1:0]           tail_ff, tail_in;
   logic [CW-1:0]           sw_ff, sw_in;
   logic [VW-1:0]           clr_ff, clr_in;
   tel_pkg::rsp_type        res_ff, res_in;
   tel_pkg::rsp_type        rsp_ff, rsp_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   logic [XW-1:0] ld_i1, ld_i2, mt_i1, mt_i2;
   logic          last_b, edge_room, tri_room, mt_last, sw_last, clr_last;
   logic          rsp_free, read_bad, match_hit;
   logic [EW-1:0] eidx;
   tel_pkg::back_state_type finish_state, sweep_state, edge_next_state, match_next_state;
   tel_pkg::rsp_type        summary;

   // edge pairs in winding order: c->a, a->b, b->c
   always_comb begin
      unique case (b_ff)
         2'd0: begin
            ld_i1 = item_ff.req.vertex_c;
            ld_i2 = item_ff.req.vertex_a;
            mt_i1 = tri_q[3*XW-1:2*XW];
            mt_i2 = tri_q[XW-1:0];
         end
         2'd1: begin
            ld_i1 = item_ff.req.vertex_a;
            ld_i2 = item_ff.req.vertex_b;
            mt_i1 = tri_q[XW-1:0];
            mt_i2 = tri_q[2*XW-1:XW];
         end
         default: begin
            ld_i1 = item_ff.req.vertex_b;
            ld_i2 = item_ff.req.vertex_c;
            mt_i1 = tri_q[2*XW-1:XW];
            mt_i2 = tri_q[3*XW-1:2*XW];
         end
      endcase
   end

   assign last_b    = (b_ff == 2'd2);
   assign edge_room = (32'(ecount_ff) < MAX_EDGES);
   assign tri_room  = (32'(tri_total_ff) < MAX_TRIANGLES);
   assign mt_last   = (32'(mt_ff) + 32'd1 >= 32'(tri_total_ff));
   assign sw_last   = (32'(sw_ff) + 32'd1 >= 32'(ecount_ff));
   assign clr_last  = (clr_ff == VW'(MAX_VERTICES - 1));
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign read_bad  = !mf_ff || (32'(item_ff.req.edge_number) >= 32'(ecount_ff));
   assign match_hit = (edge_q.hi == mt_i1) && (edge_q.f0 == edge_q.f1);
   assign eidx      = ecount_ff[EW-1:0];

   assign sweep_state      = (ecount_ff == '0) ? tel_pkg::ST_SUMMARY : tel_pkg::ST_SWEEP_RD;
   assign finish_state     = !item_ff.req.last_triangle ? tel_pkg::ST_IDLE :
                             (tri_total_ff == '0) ? sweep_state : tel_pkg::ST_MATCH_TRI;
   assign edge_next_state  = last_b ? finish_state : tel_pkg::ST_EDGE_SEL;
   assign match_next_state = !last_b ? tel_pkg::ST_MATCH_SEL :
                             mt_last ? sweep_state : tel_pkg::ST_MATCH_TRI;

   always_comb begin
      summary             = '0;
      summary.kind        = tel_pkg::KIND_SUMMARY;
      summary.status      = err_ff;
      summary.edge_total  = tel_pkg::TOTAL_WIDTH'(ecount_ff);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tel_pkg::ST_CLEAR:
            if (clr_last) state_in = tel_pkg::ST_IDLE;
         tel_pkg::ST_IDLE:
            if (item_valid) begin
               state_in = (item_data.req.action == tel_pkg::ACTION_LOAD) ?
                          tel_pkg::ST_LOAD : tel_pkg::ST_READ;
            end
         tel_pkg::ST_LOAD:
            if (!item_ff.in_range || !tri_room) state_in = finish_state;
            else state_in = tel_pkg::ST_EDGE_SEL;
         tel_pkg::ST_EDGE_SEL:
            if ((ld_i1 < ld_i2) && edge_room) state_in = tel_pkg::ST_EDGE_WR;
            else state_in = edge_next_state;
         tel_pkg::ST_EDGE_WR:
            state_in = edge_next_state;
         tel_pkg::ST_MATCH_TRI:
            state_in = tel_pkg::ST_MATCH_SEL;
         tel_pkg::ST_MATCH_SEL:
            if (mt_i1 > mt_i2) state_in = tel_pkg::ST_MATCH_HEAD;
            else state_in = match_next_state;
         tel_pkg::ST_MATCH_HEAD:
            if (head_q.valid) state_in = tel_pkg::ST_MATCH_EDGE;
            else state_in = match_next_state;
         tel_pkg::ST_MATCH_EDGE:
            state_in = tel_pkg::ST_MATCH_CHK;
         tel_pkg::ST_MATCH_CHK:
            if (match_hit || (cur_ff == tail_ff)) state_in = match_next_state;
            else state_in = tel_pkg::ST_MATCH_EDGE;
         tel_pkg::ST_SWEEP_RD:
            state_in = tel_pkg::ST_SWEEP_WR;
         tel_pkg::ST_SWEEP_WR:
            state_in = sw_last ? tel_pkg::ST_SUMMARY : tel_pkg::ST_SWEEP_RD;
         tel_pkg::ST_SUMMARY:
            if (rsp_free) state_in = tel_pkg::ST_IDLE;
         tel_pkg::ST_READ:
            state_in = read_bad ? tel_pkg::ST_RESULT : tel_pkg::ST_READ_WAIT;
         tel_pkg::ST_READ_WAIT:
            state_in = tel_pkg::ST_RESULT;
         tel_pkg::ST_RESULT:
            if (rsp_free) state_in = tel_pkg::ST_IDLE;
         default:
            state_in = tel_pkg::ST_IDLE;
      endcase
   end

   // outputs, datapath and memory controls
   always_comb begin
      item_pop     = 1'b0;
      item_in      = item_ff;
      mf_in        = mf_ff;
      err_in       = err_ff;
      tri_total_in = tri_total_ff;
      ecount_in    = ecount_ff;
      cur_tri_in   = cur_tri_ff;
      b_in         = b_ff;
      mt_in        = mt_ff;
      cur_in       = cur_ff;
      tail_in      = tail_ff;
      sw_in        = '0;
      clr_in       = clr_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      tri_we     = 1'b0;
      tri_waddr  = tri_total_ff[TW-1:0];
      tri_wdata  = {item_ff.req.vertex_c, item_ff.req.vertex_b, item_ff.req.vertex_a};
      tri_raddr  = mt_ff[TW-1:0];
      edge_we    = 1'b0;
      edge_waddr = eidx;
      edge_wdata = '{lo: ld_i1, hi: ld_i2, f0: cur_tri_ff, f1: cur_tri_ff};
      edge_raddr = cur_ff;
      next_we    = 1'b0;
      next_waddr = head_q.tail;
      next_wdata = eidx;
      head_we    = 1'b0;
      head_waddr = VW'(ld_i1);
      head_wdata = head_q.valid ? '{valid: 1'b1, first: head_q.first, tail: eidx} :
                                  '{valid: 1'b1, first: eidx, tail: eidx};
      head_raddr = VW'(ld_i1);

      unique case (state_ff)
         tel_pkg::ST_CLEAR: begin
            head_we    = 1'b1;
            head_waddr = clr_ff;
            head_wdata = '0;
            clr_in     = clr_ff + VW'(1);
         end
         tel_pkg::ST_IDLE: begin
            item_pop = item_valid;
            mt_in    = '0;
            b_in     = 2'd0;
            if (item_valid) begin
               item_in = item_data;
               // first load after a summary opens a new mesh
               if ((item_data.req.action == tel_pkg::ACTION_LOAD) && mf_ff) begin
                  mf_in        = 1'b0;
                  err_in       = tel_pkg::STATUS_OK;
                  tri_total_in = '0;
                  ecount_in    = '0;
               end
            end
         end
         tel_pkg::ST_LOAD: begin
            if (!item_ff.in_range) begin
               if (err_ff == tel_pkg::STATUS_OK) err_in = tel_pkg::STATUS_RANGE;
            end else if (!tri_room) begin
               if (err_ff == tel_pkg::STATUS_OK) err_in = tel_pkg::STATUS_FULL;
            end else begin
               tri_we       = 1'b1;
               cur_tri_in   = tri_total_ff[TW-1:0];
               tri_total_in = tri_total_ff + TCW'(1);
            end
         end
         tel_pkg::ST_EDGE_SEL: begin
            if ((ld_i1 < ld_i2) && edge_room) begin
               b_in = b_ff;
            end else begin
               if ((ld_i1 < ld_i2) && (err_ff == tel_pkg::STATUS_OK)) begin
                  err_in = tel_pkg::STATUS_FULL;
               end
               b_in = last_b ? 2'd0 : b_ff + 2'd1;
            end
         end
         tel_pkg::ST_EDGE_WR: begin
            edge_we   = 1'b1;
            head_we   = 1'b1;
            next_we   = head_q.valid;
            ecount_in = ecount_ff + CW'(1);
            b_in      = last_b ? 2'd0 : b_ff + 2'd1;
         end
         tel_pkg::ST_MATCH_TRI: begin
            b_in = 2'd0;
         end
         tel_pkg::ST_MATCH_SEL: begin
            head_raddr = VW'(mt_i2);
            if (!(mt_i1 > mt_i2)) begin
               b_in = last_b ? 2'd0 : b_ff + 2'd1;
               if (last_b) mt_in = mt_ff + TCW'(1);
            end
         end
         tel_pkg::ST_MATCH_HEAD: begin
            cur_in  = head_q.first;
            tail_in = head_q.tail;
            if (!head_q.valid) begin
               b_in = last_b ? 2'd0 : b_ff + 2'd1;
               if (last_b) mt_in = mt_ff + TCW'(1);
            end
         end
         tel_pkg::ST_MATCH_EDGE: begin
         end
         tel_pkg::ST_MATCH_CHK: begin
            edge_waddr = cur_ff;
            edge_wdata = '{lo: edge_q.lo, hi: edge_q.hi, f0: edge_q.f0,
                           f1: mt_ff[TW-1:0]};
            if (match_hit || (cur_ff == tail_ff)) begin
               edge_we = match_hit;
               b_in    = last_b ? 2'd0 : b_ff + 2'd1;
               if (last_b) mt_in = mt_ff + TCW'(1);
            end else begin
               cur_in = next_q;
            end
         end
         tel_pkg::ST_SWEEP_RD: begin
            sw_in      = sw_ff;
            edge_raddr = sw_ff[EW-1:0];
         end
         tel_pkg::ST_SWEEP_WR: begin
            sw_in      = sw_ff + CW'(1);
            head_we    = 1'b1;
            head_waddr = VW'(edge_q.lo);
            head_wdata = '0;
         end
         tel_pkg::ST_SUMMARY: begin
            if (rsp_free) begin
               rsp_in       = summary;
               rsp_valid_in = 1'b1;
               mf_in        = 1'b1;
            end
         end
         tel_pkg::ST_READ: begin
            edge_raddr    = EW'(item_ff.req.edge_number);
            res_in        = '0;
            res_in.kind   = tel_pkg::KIND_EDGE;
            res_in.status = tel_pkg::STATUS_BAD_READ;
         end
         tel_pkg::ST_READ_WAIT: begin
            res_in.kind        = tel_pkg::KIND_EDGE;
            res_in.status      = tel_pkg::STATUS_OK;
            res_in.edge_total  = tel_pkg::TOTAL_WIDTH'(ecount_ff);
            res_in.vertex_low  = edge_q.lo;
            res_in.vertex_high = edge_q.hi;
            res_in.face_first  = tel_pkg::FACE_WIDTH'(edge_q.f0);
            res_in.face_second = tel_pkg::FACE_WIDTH'(edge_q.f1);
            res_in.boundary    = (edge_q.f0 == edge_q.f1);
         end
         tel_pkg::ST_RESULT: begin
            if (rsp_free) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tel_pkg::ST_CLEAR;
         mf_ff        <= 1'b1;
         err_ff       <= tel_pkg::STATUS_OK;
         tri_total_ff <= '0;
         ecount_ff    <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         b_ff         <= 2'd0;
         mt_ff        <= '0;
         sw_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         mf_ff        <= mf_in;
         err_ff       <= err_in;
         tri_total_ff <= tri_total_in;
         ecount_ff    <= ecount_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         b_ff         <= b_in;
         mt_ff        <= mt_in;
         sw_ff        <= sw_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff    <= item_in;
      cur_tri_ff <= cur_tri_in;
      cur_ff     <= cur_in;
      tail_ff    <= tail_in;
      res_ff     <= res_in;
      rsp_ff     <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (tri_we) tri_mem[tri_waddr] <= tri_wdata;
      tri_q <= tri_mem[tri_raddr];
   end

   always_ff @(posedge clock) begin
      if (edge_we) edge_mem[edge_waddr] <= edge_wdata;
      edge_q <= edge_mem[edge_raddr];
   end

   always_ff @(posedge clock) begin
      if (next_we) next_mem[next_waddr] <= next_wdata;
      next_q <= next_mem[cur_ff];
   end

   always_ff @(posedge clock) begin
      if (head_we) head_mem[head_waddr] <= head_wdata;
      head_q <= head_mem[head_raddr];
   end

endmodule

### sim/tb.sv
// testbench for the triangle edge list builder with a built-in mesh predictor
`timescale 1ns / 1ps

module tb;

   localparam int MAX_VERT  = 4096;
   localparam int MAX_TRI   = 1024;
   localparam int MAX_EDGE  = 3072;
   localparam int LIMIT     = 1000000;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   tel_pkg::req_type              req_payload = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   tel_pkg::rsp_type              rsp_payload;
   logic                          csr_write_enable = 1'b0;
   logic [tel_pkg::CSR_WIDTH-1:0] csr_write_data = '0;

   triangle_edge_list_builder u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #4 clock = ~clock;

   // predicted mesh state, a private copy of what the block should hold
   logic [11:0] tri_vert [MAX_TRI][3];
   logic [11:0] edge_lo [MAX_EDGE];
   logic [11:0] edge_hi [MAX_EDGE];
   int          edge_f0 [MAX_EDGE];
   int          edge_f1 [MAX_EDGE];
   bit          head_ok [MAX_VERT];
   int          head_at [MAX_VERT];
   bit          link_ok [MAX_EDGE];
   int          link_at [MAX_EDGE];
   int          tri_count;
   int          edge_count;
   bit          mesh_done;
   logic [1:0]  mesh_error;
   int          vertex_limit;

   tel_pkg::rsp_type expected_rsp [$];
   int               mismatches;
   int               cycles;
   int               send_idle_pct;
   int               stall_pct;

   // ------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------
   function automatic void note_error(logic [1:0] code);
      if (mesh_error == tel_pkg::STATUS_OK) mesh_error = code;
   endfunction

   // append an ascending edge to the chain of its lower vertex
   function automatic void add_edge(logic [11:0] lo, logic [11:0] hi, int face);
      int k;
      if (edge_count >= MAX_EDGE) begin
         note_error(tel_pkg::STATUS_FULL);
         return;
      end
      edge_lo[edge_count] = lo;
      edge_hi[edge_count] = hi;
      edge_f0[edge_count] = face;
      edge_f1[edge_count] = face;
      link_ok[edge_count] = 1'b0;
      if (!head_ok[lo]) begin
         head_ok[lo] = 1'b1;
         head_at[lo] = edge_count;
      end else begin
         k = head_at[lo];
         while (link_ok[k]) k = link_at[k];
         link_ok[k] = 1'b1;
         link_at[k] = edge_count;
      end
      edge_count++;
   endfunction

   // second pass: each descending edge claims the earliest unmatched twin
   function automatic void match_neighbors();
      logic [11:0] v1, v2;
      int e;
      for (int t = 0; t < tri_count; t++) begin
         v1 = tri_vert[t][2];
         for (int b = 0; b < 3; b++) begin
            v2 = tri_vert[t][b];
            if (v1 > v2 && head_ok[v2]) begin
               e = head_at[v2];
               forever begin
                  if (edge_hi[e] == v1 && edge_f0[e] == edge_f1[e]) begin
                     edge_f1[e] = t;
                     break;
                  end
                  if (!link_ok[e]) break;
                  e = link_at[e];
               end
            end
            v1 = v2;
         end
      end
   endfunction

   // work out the result (if any) of one accepted request
   function automatic void predict_mesh(tel_pkg::req_type r);
      tel_pkg::rsp_type o;
      logic [11:0]      v [3];
      logic [11:0]      v1;
      bit               ok;
      int               lim;
      o = '0;
      if (r.action == tel_pkg::ACTION_LOAD) begin
         if (mesh_done) begin
            foreach (head_ok[i]) head_ok[i] = 1'b0;
            tri_count  = 0;
            edge_count = 0;
            mesh_error = tel_pkg::STATUS_OK;
            mesh_done  = 1'b0;
         end
         v[0] = r.vertex_a;
         v[1] = r.vertex_b;
         v[2] = r.vertex_c;
         lim  = (vertex_limit < MAX_VERT) ? vertex_limit : MAX_VERT;
         ok   = 1'b1;
         for (int b = 0; b < 3; b++) if (v[b] >= lim) ok = 1'b0;
         if (!ok) note_error(tel_pkg::STATUS_RANGE);
         else if (tri_count >= MAX_TRI) note_error(tel_pkg::STATUS_FULL);
         else begin
            for (int b = 0; b < 3; b++) tri_vert[tri_count][b] = v[b];
            v1 = v[2];
            for (int b = 0; b < 3; b++) begin
               if (v1 < v[b]) add_edge(v1, v[b], tri_count);
               v1 = v[b];
            end
            tri_count++;
         end
         if (!r.last_triangle) return;
         match_neighbors();
         mesh_done    = 1'b1;
         o.kind       = tel_pkg::KIND_SUMMARY;
         o.status     = mesh_error;
         o.edge_total = edge_count[11:0];
      end else begin
         o.kind = tel_pkg::KIND_EDGE;
         if (!mesh_done || r.edge_number >= edge_count) o.status = tel_pkg::STATUS_BAD_READ;
         else begin
            o.status      = tel_pkg::STATUS_OK;
            o.edge_total  = edge_count[11:0];
            o.vertex_low  = edge_lo[r.edge_number];
            o.vertex_high = edge_hi[r.edge_number];
            o.face_first  = edge_f0[r.edge_number][9:0];
            o.face_second = edge_f1[r.edge_number][9:0];
            o.boundary    = (edge_f0[r.edge_number] == edge_f1[r.edge_number]);
         end
      end
      expected_rsp.push_back(o);
   endfunction

   // ------------------------------------------------------------------
   // result checker
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      cycles <= cycles + 1;
      // stall pattern follows the current phase
      rsp_stall <= ($urandom_range(99) < stall_pct);
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %p", rsp_payload);
         end else begin
            if (rsp_payload !== expected_rsp[0]) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %p actual %p", expected_rsp[0], rsp_payload);
            end
            void'(expected_rsp.pop_front());
         end
      end
   end

   // runaway guard
   always @(posedge clock) begin
      if (cycles > LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------
   task automatic send_request(tel_pkg::req_type r);
      int gap;
      req_payload <= r;
      if (!req_valid) req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_mesh(r);
      // random sender gaps, otherwise valid stays high for the next request
      if ($urandom_range(99) < send_idle_pct) begin
         gap = $urandom_range(1, 3);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_load(int a, int b, int c, bit last);
      tel_pkg::req_type r;
      r = '0;
      r.action        = tel_pkg::ACTION_LOAD;
      r.vertex_a      = a[11:0];
      r.vertex_b      = b[11:0];
      r.vertex_c      = c[11:0];
      r.last_triangle = last;
      r.edge_number   = $urandom_range(4095);
      send_request(r);
   endtask

   task automatic send_read(int n);
      tel_pkg::req_type r;
      r = '0;
      r.action        = tel_pkg::ACTION_READ;
      r.vertex_a      = $urandom_range(4095);
      r.vertex_b      = $urandom_range(4095);
      r.vertex_c      = $urandom_range(4095);
      r.last_triangle = $urandom_range(1);
      r.edge_number   = n[11:0];
      send_request(r);
   endtask

   // hold the sender until every expected result has come back
   task automatic wait_results();
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
   endtask

   // drain: nothing outstanding, then a little slack for the block to settle
   task automatic wait_idle();
      if (req_valid) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic write_vertex_count(int value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value[tel_pkg::CSR_WIDTH-1:0];
      @(posedge clock);
      csr_write_enable <= 1'b0;
      vertex_limit = value;
   endtask

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------
   task automatic test_directed();
      read_before_mesh: send_read(0);
      // two triangles sharing one edge, then every edge read back
      send_load(0, 1, 2, 1'b0);
      send_read(0);                      // read while mesh is loading
      send_load(2, 1, 3, 1'b1);
      for (int n = 0; n < 5; n++) send_read(n);
      send_read(4095);
      // extreme indices
      send_load(4095, 0, 2048, 1'b0);
      send_load(0, 4095, 4095, 1'b1);
      send_read(0);
      send_read(1);
      // degenerate: all equal and self matching
      send_load(5, 5, 5, 1'b0);
      send_load(1, 2, 1, 1'b1);
      send_read(0);
      wait_idle();
      // tiny vertex space, out of range error and dropped last triangle
      write_vertex_count(1);
      send_load(0, 0, 0, 1'b0);
      send_load(0, 1, 0, 1'b1);
      send_read(0);
      wait_idle();
      write_vertex_count(16);
      send_load(3, 9, 15, 1'b0);
      send_load(15, 9, 16, 1'b0);
      send_load(9, 3, 1, 1'b1);
      send_read(0);
      send_read(2);
      wait_idle();
   endtask

   task automatic test_triangle_overflow();
      write_vertex_count(4096);
      // 1025 triangles, the last one overflows the triangle store
      for (int t = 0; t <= MAX_TRI; t++)
         send_load((t * 3) % 4090, (t * 3) % 4090 + 1, (t * 3) % 4090 + 2, t == MAX_TRI);
      send_read(0);
      send_read(2047);
      send_read(2048);
      wait_idle();
   endtask

   // random meshes, mostly well formed with shared edges, some noise
   task automatic test_random_meshes(int items);
      int sent, ntri, span, base, a, b, c, pa, pb, hold;
      sent = 0;
      while (sent < items) begin
         ntri = ($urandom_range(19) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
         span = $urandom_range(3, 24);
         base = $urandom_range(0, 4095 - span);
         pa = base;
         pb = base + 1;
         for (int t = 0; t < ntri; t++) begin
            c = base + $urandom_range(span);
            if ($urandom_range(1) && t > 0) begin
               // neighbor across the previous triangle's edge
               a = pb;
               b = pa;
            end else begin
               a = base + $urandom_range(span);
               b = base + $urandom_range(span);
            end
            if ($urandom_range(29) == 0) a = $urandom_range(4095);
            if ($urandom_range(29) == 0) c = vertex_limit + $urandom_range(20);
            if (c > 4095) c = 4095;
            send_load(a, b, c, t == ntri - 1);
            if ($urandom_range(24) == 0) send_read($urandom_range(4095));
            pa = b;
            pb = c;
            sent++;
         end
         // in about one mesh in sixteen the sender holds back until all results are in
         hold = $urandom_range(15);
         if (hold == 0) wait_results();
         for (int k = $urandom_range(1, 5); k > 0; k--) begin
            send_read($urandom_range(0, edge_count + 1));
            sent++;
         end
      end
      wait_results();
      send_read($urandom_range(4095));
      wait_idle();
   endtask

   initial begin
      tri_count     = 0;
      edge_count    = 0;
      mesh_done     = 1'b1;
      mesh_error    = tel_pkg::STATUS_OK;
      vertex_limit  = 4096;
      mismatches    = 0;
      cycles        = 0;
      send_idle_pct = 0;
      stall_pct     = 0;
      foreach (head_ok[i]) head_ok[i] = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_triangle_overflow();

      // random mesh phases, each with its own vertex count and idle and stall mix
      write_vertex_count(4096);
      send_idle_pct = 0;  stall_pct = 0;
      test_random_meshes(200);
      write_vertex_count(200);
      send_idle_pct = 61; stall_pct = 0;
      test_random_meshes(200);
      write_vertex_count(4095);
      send_idle_pct = 0;  stall_pct = 61;
      test_random_meshes(200);
      write_vertex_count(3000);
      send_idle_pct = 23; stall_pct = 23;
      test_random_meshes(200);

      wait_idle();
      repeat (200) @(posedge clock);
      if (mismatches == 0 && expected_rsp.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

### files.f
hw/rtl/tel_pkg.sv
hw/rtl/tel_front.sv
hw/rtl/tel_back.sv
hw/rtl/triangle_edge_list_builder.sv
sim/tb.sv
